// ----- design/aalu_pkg.sv -----
// Shared widths and operation codes for the accumulator ALU.
package aalu_pkg;

  localparam int unsigned KIND_W = 5;
  localparam int unsigned BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [KIND_W-1:0] {
    OP_LDA = 5'd0,
    OP_LDX = 5'd1,
    OP_LDY = 5'd2,
    OP_ADC = 5'd3,
    OP_SBC = 5'd4,
    OP_AND = 5'd5,
    OP_ORA = 5'd6,
    OP_EOR = 5'd7,
    OP_ASL = 5'd8,
    OP_LSR = 5'd9,
    OP_ROL = 5'd10,
    OP_ROR = 5'd11,
    OP_TAX = 5'd12,
    OP_TAY = 5'd13,
    OP_TXA = 5'd14,
    OP_TYA = 5'd15,
    OP_CLC = 5'd16,
    OP_SEC = 5'd17,
    OP_CLI = 5'd18,
    OP_SEI = 5'd19,
    OP_SED = 5'd20
  } kind_t;

  typedef struct packed {
    logic c;
    logic z;
    logic n;
    logic v;
    logic i;
    logic d;
  } flags_t;

endpackage

// ----- design/aalu_in_if.sv -----
// Input channel: operation kind and operand byte.
interface aalu_in_if
  import aalu_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  byte_t               operand;

  modport source (output valid, output kind, output operand, input ready);
  modport sink   (input valid, input kind, input operand, output ready);
endinterface

// ----- design/aalu_out_if.sv -----
// Result channel: registers and flags after each item.
interface aalu_out_if
  import aalu_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t acc_out;
  byte_t x_out;
  byte_t y_out;
  logic  carry_out;
  logic  zero_out;
  logic  negative_out;
  logic  overflow_out;
  logic  irq_disable_out;
  logic  decimal_out;

  modport source (
    output valid, output acc_out, output x_out, output y_out, output carry_out,
    output zero_out, output negative_out, output overflow_out,
    output irq_disable_out, output decimal_out, input ready
  );
  modport sink (
    input valid, input acc_out, input x_out, input y_out, input carry_out,
    input zero_out, input negative_out, input overflow_out,
    input irq_disable_out, input decimal_out, output ready
  );
endinterface

// ----- design/accumulator_alu_with_flags.sv -----
// Accumulator ALU top level: A, X, Y and flags, one item per cycle while results drain.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the architectural registers double as the
// result register, so an item is taken whenever the result slot is empty or drains.
// Reset: A, X, Y and C, Z, N, V, D clear, I sets; no result pending.
module accumulator_alu_with_flags
  import aalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  aalu_in_if.sink     in_ch,
  aalu_out_if.source  out_ch
);

  byte_t  a_r, a_nxt;
  byte_t  x_r, x_nxt;
  byte_t  y_r, y_nxt;
  flags_t f_r, f_nxt;
  logic   out_valid_r;
  logic   accept;

  logic [BYTE_W:0] sum;
  byte_t           m_add;
  byte_t           zn_val;
  logic            zn_upd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    a_nxt  = a_r;
    x_nxt  = x_r;
    y_nxt  = y_r;
    f_nxt  = f_r;
    zn_val = a_r;
    zn_upd = 1'b0;
    m_add  = (in_ch.kind == OP_SBC) ? ~in_ch.operand : in_ch.operand;
    sum    = {1'b0, a_r} + {1'b0, m_add} + {{BYTE_W{1'b0}}, f_r.c};
    case (in_ch.kind)
      OP_LDA: begin a_nxt = in_ch.operand; zn_val = a_nxt; zn_upd = 1'b1; end
      OP_LDX: begin x_nxt = in_ch.operand; zn_val = x_nxt; zn_upd = 1'b1; end
      OP_LDY: begin y_nxt = in_ch.operand; zn_val = y_nxt; zn_upd = 1'b1; end
      OP_ADC, OP_SBC: begin
        a_nxt   = sum[BYTE_W-1:0];
        f_nxt.c = sum[BYTE_W];
        f_nxt.v = ~(a_r[BYTE_W-1] ^ m_add[BYTE_W-1]) & (a_r[BYTE_W-1] ^ a_nxt[BYTE_W-1]);
        zn_val  = a_nxt;
        zn_upd  = 1'b1;
      end
      OP_AND: begin a_nxt = a_r & in_ch.operand; zn_val = a_nxt; zn_upd = 1'b1; end
      OP_ORA: begin a_nxt = a_r | in_ch.operand; zn_val = a_nxt; zn_upd = 1'b1; end
      OP_EOR: begin a_nxt = a_r ^ in_ch.operand; zn_val = a_nxt; zn_upd = 1'b1; end
      OP_ASL: begin
        f_nxt.c = a_r[BYTE_W-1];
        a_nxt   = {a_r[BYTE_W-2:0], 1'b0};
        zn_val  = a_nxt;
        zn_upd  = 1'b1;
      end
      OP_LSR: begin
        f_nxt.c = a_r[0];
        a_nxt   = {1'b0, a_r[BYTE_W-1:1]};
        zn_val  = a_nxt;
        zn_upd  = 1'b1;
      end
      OP_ROL: begin
        f_nxt.c = a_r[BYTE_W-1];
        a_nxt   = {a_r[BYTE_W-2:0], f_r.c};
        zn_val  = a_nxt;
        zn_upd  = 1'b1;
      end
      OP_ROR: begin
        f_nxt.c = a_r[0];
        a_nxt   = {f_r.c, a_r[BYTE_W-1:1]};
        zn_val  = a_nxt;
        zn_upd  = 1'b1;
      end
      OP_TAX: begin x_nxt = a_r; zn_val = a_r; zn_upd = 1'b1; end
      OP_TAY: begin y_nxt = a_r; zn_val = a_r; zn_upd = 1'b1; end
      OP_TXA: begin a_nxt = x_r; zn_val = x_r; zn_upd = 1'b1; end
      OP_TYA: begin a_nxt = y_r; zn_val = y_r; zn_upd = 1'b1; end
      OP_CLC: f_nxt.c = 1'b0;
      OP_SEC: f_nxt.c = 1'b1;
      OP_CLI: f_nxt.i = 1'b0;
      OP_SEI: f_nxt.i = 1'b1;
      OP_SED: f_nxt.d = 1'b1;
      default: ;
    endcase
    if (zn_upd) begin
      f_nxt.z = (zn_val == '0);
      f_nxt.n = zn_val[BYTE_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r         <= '0;
      x_r         <= '0;
      y_r         <= '0;
      f_r         <= '{c: 1'b0, z: 1'b0, n: 1'b0, v: 1'b0, i: 1'b1, d: 1'b0};
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_r <= a_nxt;
        x_r <= x_nxt;
        y_r <= y_nxt;
        f_r <= f_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.acc_out         = a_r;
  assign out_ch.x_out           = x_r;
  assign out_ch.y_out           = y_r;
  assign out_ch.carry_out       = f_r.c;
  assign out_ch.zero_out        = f_r.z;
  assign out_ch.negative_out    = f_r.n;
  assign out_ch.overflow_out    = f_r.v;
  assign out_ch.irq_disable_out = f_r.i;
  assign out_ch.decimal_out     = f_r.d;

endmodule

// ----- sim/testbench.sv -----
// Testbench for accumulator_alu_with_flags: random and directed items against a predictor.
module testbench;
  import aalu_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 5'd21;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 5'd31;
  localparam int RANDOM_ITEMS = 1875;
  localparam int QUIET_TAIL   = 250;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    byte_t             operand;
  } instr_t;

  typedef struct packed {
    byte_t  a;
    byte_t  x;
    byte_t  y;
    flags_t f;
  } regs_t;

  logic clk = 1'b0;
  logic rst_n;

  aalu_in_if  in_ch ();
  aalu_out_if out_ch ();

  accumulator_alu_with_flags dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  instr_t instr_q[$];
  regs_t  arch_state_q[$];

  byte_t  acc_q, x_q, y_q;
  flags_t flags_q;

  int  total_items;
  int  results_seen;
  int  mismatches;
  int  cycle_count;
  int  in_gap;
  int  out_gap;
  int  hold_left;
  bit  hold_done;
  bit  quiet;
  int  kind_hits [32];

  // Architectural effect of one item; updates the predicted registers.
  function automatic regs_t execute_op(logic [KIND_W-1:0] k, byte_t m);
    logic [8:0] sum;
    byte_t      addend;
    byte_t      res;
    logic       set_zn;
    regs_t      r;
    set_zn = 1'b1;
    res    = acc_q;
    case (k)
      OP_LDA: begin acc_q = m; res = m; end
      OP_LDX: begin x_q = m; res = m; end
      OP_LDY: begin y_q = m; res = m; end
      OP_ADC, OP_SBC: begin
        addend = (k == OP_SBC) ? ~m : m;
        sum = {1'b0, acc_q} + {1'b0, addend} + {8'd0, flags_q.c};
        res = sum[7:0];
        flags_q.c = sum[8];
        flags_q.v = ~(acc_q[7] ^ addend[7]) & (acc_q[7] ^ res[7]);
        acc_q = res;
      end
      OP_AND: begin acc_q = acc_q & m; res = acc_q; end
      OP_ORA: begin acc_q = acc_q | m; res = acc_q; end
      OP_EOR: begin acc_q = acc_q ^ m; res = acc_q; end
      OP_ASL: begin
        flags_q.c = acc_q[7];
        acc_q = {acc_q[6:0], 1'b0};
        res = acc_q;
      end
      OP_LSR: begin
        flags_q.c = acc_q[0];
        acc_q = {1'b0, acc_q[7:1]};
        res = acc_q;
      end
      OP_ROL: begin
        res = {acc_q[6:0], flags_q.c};
        flags_q.c = acc_q[7];
        acc_q = res;
      end
      OP_ROR: begin
        res = {flags_q.c, acc_q[7:1]};
        flags_q.c = acc_q[0];
        acc_q = res;
      end
      OP_TAX: begin x_q = acc_q; res = acc_q; end
      OP_TAY: begin y_q = acc_q; res = acc_q; end
      OP_TXA: begin acc_q = x_q; res = x_q; end
      OP_TYA: begin acc_q = y_q; res = y_q; end
      OP_CLC: begin flags_q.c = 1'b0; set_zn = 1'b0; end
      OP_SEC: begin flags_q.c = 1'b1; set_zn = 1'b0; end
      OP_CLI: begin flags_q.i = 1'b0; set_zn = 1'b0; end
      OP_SEI: begin flags_q.i = 1'b1; set_zn = 1'b0; end
      OP_SED: begin flags_q.d = 1'b1; set_zn = 1'b0; end
      default: set_zn = 1'b0;
    endcase
    if (set_zn) begin
      flags_q.z = (res == 8'h00);
      flags_q.n = res[7];
    end
    r.a = acc_q;
    r.x = x_q;
    r.y = y_q;
    r.f = flags_q;
    return r;
  endfunction

  function automatic byte_t pick_operand();
    byte_t corners [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 4)];
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic push_instr(logic [KIND_W-1:0] k, byte_t m);
    instr_t it;
    it.kind = k;
    it.operand = m;
    instr_q.push_back(it);
    total_items++;
  endtask

  task automatic check_field(string name, logic [7:0] exp, logic [7:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  task automatic check_flag(string name, logic exp, logic act);
    if (act !== exp) begin
      $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // Driver
  always @(posedge clk) begin
    instr_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        arch_state_q.push_back(execute_op(in_ch.kind, in_ch.operand));
        kind_hits[in_ch.kind]++;
      end
      quiet = instr_q.size() < QUIET_TAIL;
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap == 0 && !quiet && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 15);
        end
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (instr_q.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else begin
          nxt = instr_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.kind    <= nxt.kind;
          in_ch.operand <= nxt.operand;
        end
      end
    end
  end

  // Monitor and receiver stalls
  always @(posedge clk) begin
    regs_t exp;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (arch_state_q.size() == 0) begin
          $display("%0t: unexpected result: acc %02h x %02h y %02h", $time,
                   out_ch.acc_out, out_ch.x_out, out_ch.y_out);
          mismatches++;
        end else begin
          exp = arch_state_q.pop_front();
          check_field("acc",  exp.a,   out_ch.acc_out);
          check_field("x",    exp.x,   out_ch.x_out);
          check_field("y",    exp.y,   out_ch.y_out);
          check_flag("C",     exp.f.c, out_ch.carry_out);
          check_flag("Z",     exp.f.z, out_ch.zero_out);
          check_flag("N",     exp.f.n, out_ch.negative_out);
          check_flag("V",     exp.f.v, out_ch.overflow_out);
          check_flag("I",     exp.f.i, out_ch.irq_disable_out);
          check_flag("D",     exp.f.d, out_ch.decimal_out);
        end
        results_seen++;
      end
      // long hold-off once, so the result slot fills and input backs up
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end else if (out_gap > 0) begin
        out_gap--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 15);
      end
      out_ch.ready <= (hold_left == 0) && (out_gap == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int kinds_hit;
    in_ch.valid   = 1'b0;
    in_ch.kind    = '0;
    in_ch.operand = '0;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;
    acc_q   = '0;
    x_q     = '0;
    y_q     = '0;
    flags_q = '0;
    flags_q.i = 1'b1;

    // directed: load corners, ADC/SBC overflow and carry, logic, shifts, transfers, flags, unused kinds
    push_instr(OP_LDA, 8'h00);
    push_instr(OP_LDA, 8'h7F);
    push_instr(OP_ADC, 8'h01);
    push_instr(OP_ADC, 8'hFF);
    push_instr(OP_SBC, 8'h00);
    push_instr(OP_SBC, 8'h80);
    push_instr(OP_AND, 8'hF0);
    push_instr(OP_ORA, 8'h0F);
    push_instr(OP_EOR, 8'hFF);
    push_instr(OP_ASL, 8'hFF);
    push_instr(OP_LSR, 8'h00);
    push_instr(OP_SEC, 8'hAA);
    push_instr(OP_ROL, 8'h55);
    push_instr(OP_ROR, 8'h00);
    push_instr(OP_LDX, 8'hFF);
    push_instr(OP_TXA, 8'h00);
    push_instr(OP_LDY, 8'h00);
    push_instr(OP_TYA, 8'hFF);
    push_instr(OP_TAX, 8'h80);
    push_instr(OP_TAY, 8'h01);
    push_instr(OP_CLC, 8'hFF);
    push_instr(OP_CLI, 8'h00);
    push_instr(OP_SEI, 8'hFF);
    push_instr(KIND_UNUSED_LO, 8'h80);
    push_instr(OP_SED, 8'h7F);
    push_instr(KIND_UNUSED_HI, 8'hFF);

    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        push_instr(5'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), pick_operand());
      else
        push_instr(5'($urandom_range(OP_LDA, OP_SED)), pick_operand());
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (results_seen < total_items) @(posedge clk);
    repeat (5) @(posedge clk);

    kinds_hit = 0;
    foreach (kind_hits[k]) if (kind_hits[k] > 0) kinds_hit++;
    $display("Ran %0d items through the ALU; %0d of 32 kind codes seen, unused included.",
             total_items, kinds_hit);
    $display("Random receiver stalls plus one %0d-cycle hold-off with the sender still pushing.",
             HOLD_CYCLES);
    if (mismatches == 0 && arch_state_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (arch_state_q.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, arch_state_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
